// File: hdl/skf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sticky keys filter package
// Shared constants, codes, command and status types and the modifier lookup.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 16;

  localparam logic [3:0] COUNT_MAX = 4'd15;

  localparam logic [1:0] KIND_KEY     = 2'd0;
  localparam logic [1:0] KIND_POINTER = 2'd1;
  localparam logic [1:0] KIND_TOUCH   = 2'd2;

  localparam logic [1:0] ACTION_DOWN = 2'd0;
  localparam logic [1:0] ACTION_UP   = 2'd1;

  localparam logic [1:0] DISP_PASS    = 2'd0;
  localparam logic [1:0] DISP_CLICK   = 2'd1;
  localparam logic [1:0] DISP_TRIGGER = 2'd2;
  localparam logic [1:0] DISP_REPLAY  = 2'd3;

  localparam logic [9:0] SCAN_SHIFT_R     = 10'd54;
  localparam logic [9:0] SCAN_SHIFT_L     = 10'd42;
  localparam logic [9:0] SCAN_ALT_R       = 10'd100;
  localparam logic [9:0] SCAN_ALT_L       = 10'd56;
  localparam logic [9:0] SCAN_CTRL_R      = 10'd97;
  localparam logic [9:0] SCAN_CTRL_L      = 10'd29;
  localparam logic [9:0] SCAN_META_R      = 10'd126;
  localparam logic [9:0] SCAN_META_L      = 10'd125;
  localparam logic [9:0] SCAN_CAPS_LOCK   = 10'd58;
  localparam logic [9:0] SCAN_SCREEN_LOCK = 10'd152;
  localparam logic [9:0] SCAN_NUM_LOCK    = 10'd69;

  typedef struct packed {
    logic capture;
    logic load_first;
    logic load_replay;
  } skf_cmd_t;

  typedef struct packed {
    logic out_free;
    logic flush_more;
    logic replay_last;
  } skf_sts_t;

  function automatic logic modifier_match(input logic [9:0] code);
    logic hit;
    hit = 1'b0;
    case (code) inside
      SCAN_SHIFT_R, SCAN_SHIFT_L, SCAN_ALT_R, SCAN_ALT_L,
      SCAN_CTRL_R, SCAN_CTRL_L, SCAN_META_R, SCAN_META_L,
      SCAN_CAPS_LOCK, SCAN_SCREEN_LOCK, SCAN_NUM_LOCK: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// File: hdl/sticky_modifier_key_filter.sv
`timescale 1ns / 1ps
// An accepted event is first captured into the event registers; its first result is then
// loaded into the result register once that register is free. The block takes no new
// event until its first result and each release that a trigger replays are loaded;
// each replay waits on the registered queue read. An output stall holds every load.
// Reset clears the modifier count, the chord flag and the queue fill and sets the stored
// chord setting to 1; the queue contents are not cleared.
// ----------------------------------------------------------------------------
// Sticky modifier key filter
// Captures modifier releases and replays them after the next triggering release.
// ----------------------------------------------------------------------------
module sticky_modifier_key_filter
  import skf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        disable_on_chord,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  event_kind,
  input  logic [15:0] event_tag,
  input  logic [9:0]  key_code,
  input  logic [1:0]  key_action,
  input  logic        pointer_button_up,
  input  logic [3:0]  touch_count,
  input  logic        touch_first_up,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  disposition,
  output logic [15:0] out_tag,
  output logic [9:0]  out_key,
  output logic        last,
  output logic        queue_overflow
);

  skf_cmd_t cmd;
  skf_sts_t sts;

  assign cfg_ready = 1'b1;

  skf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  skf_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid && cfg_ready),
    .cfg_data          (disable_on_chord),
    .event_kind        (event_kind),
    .event_tag         (event_tag),
    .key_code          (key_code),
    .key_action        (key_action),
    .pointer_button_up (pointer_button_up),
    .touch_count       (touch_count),
    .touch_first_up    (touch_first_up),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .disposition       (disposition),
    .out_tag           (out_tag),
    .out_key           (out_key),
    .last              (last),
    .queue_overflow    (queue_overflow),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

// File: hdl/skf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sticky keys filter controller
// Sequences capture, first result and replay of the held release queue.
// ----------------------------------------------------------------------------
module skf_ctrl
  import skf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  skf_sts_t sts,
  output skf_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_READ,
    S_REPLAY
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.out_free) begin
          cmd.load_first = 1'b1;
          state_next = sts.flush_more ? S_READ : S_IDLE;
        end
      end
      S_READ: begin
        state_next = S_REPLAY;
      end
      S_REPLAY: begin
        if (sts.out_free) begin
          cmd.load_replay = 1'b1;
          state_next = sts.replay_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      in_stall <= 1'b0;
    end else begin
      state <= state_next;
      in_stall <= (state_next != S_IDLE);
    end
  end

endmodule

// File: hdl/skf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sticky keys filter datapath
// Event registers, modifier count, chord flag, release queue and result register.
// ----------------------------------------------------------------------------
module skf_dp
  import skf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_data,
  input  logic [1:0]  event_kind,
  input  logic [15:0] event_tag,
  input  logic [9:0]  key_code,
  input  logic [1:0]  key_action,
  input  logic        pointer_button_up,
  input  logic [3:0]  touch_count,
  input  logic        touch_first_up,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [1:0]  disposition,
  output logic [15:0] out_tag,
  output logic [9:0]  out_key,
  output logic        last,
  output logic        queue_overflow,
  input  skf_cmd_t    cmd,
  output skf_sts_t    sts
);

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

  logic              chord_cfg;
  logic [3:0]        held_modifiers;
  logic              chord_disabled;
  logic [FILL_W-1:0] held_fill;
  logic [FILL_W-1:0] ptr;

  logic [15:0] held_tags [QUEUE_DEPTH];
  logic [9:0]  held_keys [QUEUE_DEPTH];
  logic [15:0] rd_tag;
  logic [9:0]  rd_key;

  logic [1:0]  ev_kind;
  logic [15:0] ev_tag;
  logic [9:0]  ev_code;
  logic [1:0]  ev_action;
  logic        ev_btn_up;
  logic [3:0]  ev_tcount;
  logic        ev_tfirst_up;

  logic        ev_mod;
  logic        mod_down;
  logic        mod_up;
  logic        trigger;
  logic [3:0]  count_inc;
  logic [3:0]  count_dec;
  logic        queue_full;
  logic [FILL_W-1:0] ptr_plus;

  assign ev_mod     = modifier_match(ev_code);
  assign mod_down   = (ev_kind == KIND_KEY) && ev_mod && (ev_action == ACTION_DOWN);
  assign mod_up     = (ev_kind == KIND_KEY) && ev_mod && (ev_action == ACTION_UP);
  assign trigger    = ((ev_kind == KIND_POINTER) && ev_btn_up)
                   || ((ev_kind == KIND_TOUCH) && (ev_tcount == 4'd1) && ev_tfirst_up)
                   || ((ev_kind == KIND_KEY) && !ev_mod && (ev_action == ACTION_UP));
  assign count_inc  = (held_modifiers == COUNT_MAX) ? held_modifiers : held_modifiers + 4'd1;
  assign count_dec  = (held_modifiers == 4'd0) ? held_modifiers : held_modifiers - 4'd1;
  assign queue_full = (held_fill >= FILL_FULL);
  assign ptr_plus   = ptr + FILL_W'(1);

  assign sts.out_free    = !out_valid || !out_stall;
  assign sts.flush_more  = trigger && (held_fill != '0);
  assign sts.replay_last = (ptr_plus == held_fill);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ev_kind <= event_kind;
      ev_tag <= event_tag;
      ev_code <= key_code;
      ev_action <= key_action;
      ev_btn_up <= pointer_button_up;
      ev_tcount <= touch_count;
      ev_tfirst_up <= touch_first_up;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_first && mod_up && !chord_disabled && !queue_full) begin
      held_tags[held_fill[IDX_W-1:0]] <= ev_tag;
      held_keys[held_fill[IDX_W-1:0]] <= ev_code;
    end
    rd_tag <= held_tags[ptr[IDX_W-1:0]];
    rd_key <= held_keys[ptr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chord_cfg <= 1'b1;
      held_modifiers <= '0;
      chord_disabled <= 1'b0;
      held_fill <= '0;
      ptr <= '0;
    end else begin
      if (cfg_valid) begin
        chord_cfg <= cfg_data;
      end
      if (cmd.load_first) begin
        ptr <= '0;
        if (mod_down) begin
          held_modifiers <= count_inc;
          if (!chord_disabled) begin
            chord_disabled <= chord_cfg && (count_inc > 4'd1);
          end
        end else if (mod_up) begin
          held_modifiers <= count_dec;
          if (chord_disabled) begin
            if (count_dec == 4'd0) begin
              chord_disabled <= 1'b0;
            end
          end else if (!queue_full) begin
            held_fill <= held_fill + FILL_W'(1);
          end
        end
      end
      if (cmd.load_replay) begin
        ptr <= ptr_plus;
        if (sts.replay_last) begin
          held_fill <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_first || cmd.load_replay) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_first) begin
      out_tag <= ev_tag;
      out_key <= '0;
      last <= 1'b1;
      queue_overflow <= 1'b0;
      disposition <= DISP_PASS;
      if (trigger) begin
        disposition <= DISP_TRIGGER;
        last <= (held_fill == '0);
      end else if (mod_up && !chord_disabled) begin
        out_key <= ev_code;
        if (queue_full) begin
          queue_overflow <= 1'b1;
        end else begin
          disposition <= DISP_CLICK;
        end
      end
    end else if (cmd.load_replay) begin
      disposition <= DISP_REPLAY;
      out_tag <= rd_tag;
      out_key <= rd_key;
      last <= sts.replay_last;
      queue_overflow <= 1'b0;
    end
  end

endmodule

// File: hdl/skf_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sticky keys filter checker
// Port-level properties of the filter, bound to the top level.
// ----------------------------------------------------------------------------
module skf_chk
  import skf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  disposition,
  input logic [15:0] out_tag,
  input logic [9:0]  out_key,
  input logic        last,
  input logic        queue_overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_tag) && $stable(out_key)
      && $stable(disposition) && $stable(last))
    else $error("Stalled result transaction changed.");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("Result or stall active after reset.");

  a_overflow_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && queue_overflow |-> (disposition == DISP_PASS) && last)
    else $error("Overflow result is not a final pass-through.");

  a_busy_in_flush: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("Input accepted while a replay is still in progress.");

  a_replay_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && (disposition == DISP_REPLAY) |-> !queue_overflow)
    else $error("Replay transaction flagged as overflow.");

endmodule

bind sticky_modifier_key_filter skf_chk u_skf_chk (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .disposition    (disposition),
  .out_tag        (out_tag),
  .out_key        (out_key),
  .last           (last),
  .queue_overflow (queue_overflow)
);

// File: test/tb_sticky_modifier_key_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sticky modifier key filter testbench
// Drives key, pointer, touch and other events through the filter, predicts
// every dispatched result and checks the result stream in order. A directed
// pass covers the special cases. Saturation and queue overflow runs and a
// long output hold-off follow. Random chord sequences then run under random
// chord settings with changing idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_sticky_modifier_key_filter;
  import skf_pkg::*;

  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_ITEMS = 30;
  localparam int BATCH_ITEMS = 8;
  localparam int BATCHES = 13;

  localparam logic [1:0] KIND_OTHER = 2'd3;
  localparam logic [1:0] ACTION_REPEAT = 2'd2;
  localparam logic [1:0] ACTION_UNUSED = 2'd3;
  localparam logic [9:0] KEY_PLAIN = 10'd30;

  localparam logic [10:0][9:0] MOD_KEYS = {
    SCAN_SHIFT_R, SCAN_SHIFT_L, SCAN_ALT_R, SCAN_ALT_L, SCAN_CTRL_R,
    SCAN_CTRL_L, SCAN_META_R, SCAN_META_L, SCAN_CAPS_LOCK, SCAN_SCREEN_LOCK,
    SCAN_NUM_LOCK
  };

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] tag;
    logic [9:0]  code;
    logic [1:0]  action;
    logic        btn_up;
    logic [3:0]  tcount;
    logic        tfirst_up;
  } input_event_t;

  typedef struct packed {
    logic [1:0]  disp;
    logic [15:0] tag;
    logic [9:0]  key;
    logic        last;
    logic        ovf;
  } dispatch_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        disable_on_chord = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  event_kind = '0;
  logic [15:0] event_tag = '0;
  logic [9:0]  key_code = '0;
  logic [1:0]  key_action = '0;
  logic        pointer_button_up = 1'b0;
  logic [3:0]  touch_count = '0;
  logic        touch_first_up = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  disposition;
  logic [15:0] out_tag;
  logic [9:0]  out_key;
  logic        last;
  logic        queue_overflow;

  input_event_t pending_events[$];
  dispatch_t    expected_dispatches[$];
  input_event_t drv_ev;

  logic [3:0]  mod_down_cnt = '0;
  logic        chord_flag = 1'b0;
  logic        chord_cfg = 1'b1;
  logic [15:0] stash_tags [QUEUE_DEPTH_DEFAULT];
  logic [9:0]  stash_keys [QUEUE_DEPTH_DEFAULT];
  int          stash_fill = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int queued_cnt = 0;
  int accepted_cnt = 0;
  int checked_cnt = 0;
  int replay_cnt = 0;
  int overflow_cnt = 0;
  int fail_cnt = 0;
  int cycle_cnt = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;

  sticky_modifier_key_filter DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .disable_on_chord (disable_on_chord),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .event_kind       (event_kind),
    .event_tag        (event_tag),
    .key_code         (key_code),
    .key_action       (key_action),
    .pointer_button_up(pointer_button_up),
    .touch_count      (touch_count),
    .touch_first_up   (touch_first_up),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .disposition      (disposition),
    .out_tag          (out_tag),
    .out_key          (out_key),
    .last             (last),
    .queue_overflow   (queue_overflow)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic logic tb_modifier_match(input logic [9:0] code);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 11; i++) begin
      if (MOD_KEYS[i] == code) hit = 1'b1;
    end
    return hit;
  endfunction

  task automatic predict_dispatch(input input_event_t ev);
    dispatch_t r;
    logic      trig;
    r = '{disp: DISP_PASS, tag: ev.tag, key: '0, last: 1'b1, ovf: 1'b0};
    trig = 1'b0;
    case (ev.kind)
      KIND_POINTER: trig = ev.btn_up;
      KIND_TOUCH: trig = (ev.tcount == 4'd1) && ev.tfirst_up;
      KIND_KEY: begin
        if (!tb_modifier_match(ev.code)) begin
          trig = (ev.action == ACTION_UP);
        end else if (ev.action == ACTION_DOWN) begin
          if (mod_down_cnt != COUNT_MAX) mod_down_cnt = mod_down_cnt + 4'd1;
          if (!chord_flag) chord_flag = chord_cfg && (mod_down_cnt > 4'd1);
        end else if (ev.action == ACTION_UP) begin
          if (mod_down_cnt != 4'd0) mod_down_cnt = mod_down_cnt - 4'd1;
          if (chord_flag) begin
            if (mod_down_cnt == 4'd0) chord_flag = 1'b0;
          end else if (stash_fill >= QUEUE_DEPTH_DEFAULT) begin
            r.key = ev.code;
            r.ovf = 1'b1;
          end else begin
            stash_tags[stash_fill] = ev.tag;
            stash_keys[stash_fill] = ev.code;
            stash_fill++;
            r.disp = DISP_CLICK;
            r.key = ev.code;
          end
        end
      end
      default: ;
    endcase
    if (trig) begin
      r.disp = DISP_TRIGGER;
      r.last = (stash_fill == 0);
      expected_dispatches.push_back(r);
      for (int i = 0; i < stash_fill; i++) begin
        r = '{disp: DISP_REPLAY, tag: stash_tags[i], key: stash_keys[i],
              last: (i + 1 == stash_fill), ovf: 1'b0};
        expected_dispatches.push_back(r);
      end
      stash_fill = 0;
    end else begin
      expected_dispatches.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_dispatch(drv_ev);
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_ev = pending_events.pop_front();
          in_valid <= 1'b1;
          event_kind <= drv_ev.kind;
          event_tag <= drv_ev.tag;
          key_code <= drv_ev.code;
          key_action <= drv_ev.action;
          pointer_button_up <= drv_ev.btn_up;
          touch_count <= drv_ev.tcount;
          touch_first_up <= drv_ev.tfirst_up;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input dispatch_t want,
                                 input dispatch_t got);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("%0t %s: expected disp=%0d tag=%h key=%0d last=%b ovf=%b", $realtime,
               what, want.disp, want.tag, want.key, want.last, want.ovf);
      $display("%0t %s: actual   disp=%0d tag=%h key=%0d last=%b ovf=%b", $realtime,
               what, got.disp, got.tag, got.key, got.last, got.ovf);
    end
  endtask

  always @(posedge clk) begin
    dispatch_t got;
    dispatch_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{disp: disposition, tag: out_tag, key: out_key, last: last,
                ovf: queue_overflow};
        if (expected_dispatches.size() == 0) begin
          report_mismatch("unexpected transaction", '0, got);
        end else begin
          want = expected_dispatches.pop_front();
          checked_cnt++;
          if (got.disp == DISP_REPLAY) replay_cnt++;
          if (got.ovf) overflow_cnt++;
          if (got.disp !== want.disp || got.tag !== want.tag || got.key !== want.key ||
              got.last !== want.last || got.ovf !== want.ovf) begin
            report_mismatch("mismatch", want, got);
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_left <= HOLD_CYCLES;
      hold_seen <= hold_req;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb_sticky_modifier_key_filter failed");
      $finish;
    end
  end

  function automatic input_event_t make_event(input logic [1:0] kind,
                                              input logic [15:0] tag,
                                              input logic [9:0] code,
                                              input logic [1:0] action,
                                              input logic btn_up,
                                              input logic [3:0] tcount,
                                              input logic tfirst_up);
    input_event_t ev;
    ev = '{kind: kind, tag: tag, code: code, action: action, btn_up: btn_up,
           tcount: tcount, tfirst_up: tfirst_up};
    return ev;
  endfunction

  function automatic input_event_t any_event();
    return make_event(2'($urandom_range(3)), 16'($urandom), 10'($urandom_range(767)),
                      2'($urandom_range(3)), 1'($urandom), 4'($urandom_range(15)),
                      1'($urandom));
  endfunction

  function automatic input_event_t keyed_event(input logic [9:0] code,
                                               input logic [1:0] action);
    input_event_t ev;
    ev = any_event();
    ev.kind = KIND_KEY;
    ev.code = code;
    ev.action = action;
    return ev;
  endfunction

  function automatic logic [9:0] any_modifier();
    return MOD_KEYS[$urandom_range(10)];
  endfunction

  function automatic input_event_t trigger_event();
    input_event_t ev;
    logic [9:0]   code;
    ev = any_event();
    case ($urandom_range(2))
      0: begin
        do code = 10'($urandom_range(767)); while (tb_modifier_match(code));
        ev.kind = KIND_KEY;
        ev.code = code;
        ev.action = ACTION_UP;
      end
      1: begin
        ev.kind = KIND_POINTER;
        ev.btn_up = 1'b1;
      end
      default: begin
        ev.kind = KIND_TOUCH;
        ev.tcount = 4'd1;
        ev.tfirst_up = 1'b1;
      end
    endcase
    return ev;
  endfunction

  task automatic queue_event(input input_event_t ev);
    pending_events.push_back(ev);
    queued_cnt++;
  endtask

  task automatic queue_chord_run();
    logic [9:0] held[$];
    int         n;
    int         pick;
    n = $urandom_range(1, 3);
    repeat (n) begin
      held.push_back(any_modifier());
      queue_event(keyed_event(held[$], ACTION_DOWN));
    end
    if ($urandom_range(3) == 0) queue_event(keyed_event(held[0], ACTION_REPEAT));
    if ($urandom_range(4) == 0) queue_event(any_event());
    while (held.size() != 0) begin
      pick = $urandom_range(held.size() - 1);
      queue_event(keyed_event(held[pick], ACTION_UP));
      held.delete(pick);
    end
    if ($urandom_range(9) != 0) queue_event(trigger_event());
  endtask

  task automatic settle_block();
    wait (accepted_cnt == queued_cnt);
    while (expected_dispatches.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_chord_cfg(input logic value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    disable_on_chord <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    chord_cfg = value;
  endtask

  task automatic queue_saturation_run();
    repeat (17) queue_event(keyed_event(any_modifier(), ACTION_DOWN));
    repeat (18) queue_event(keyed_event(any_modifier(), ACTION_UP));
    queue_event(trigger_event());
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      1: begin send_idle_pct = 75; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 75; end
      3: begin send_idle_pct = 13; recv_stall_pct = 13; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  initial begin
    int start_cnt;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    queue_event(make_event(KIND_KEY, 16'h0000, SCAN_SHIFT_L, ACTION_DOWN, 0, 0, 0));
    queue_event(make_event(KIND_KEY, 16'hFFFF, SCAN_SHIFT_L, ACTION_UP, 1, 15, 1));
    queue_event(make_event(KIND_KEY, 16'h1234, KEY_PLAIN, ACTION_UP, 0, 0, 0));
    queue_event(make_event(KIND_KEY, 16'h0101, SCAN_CTRL_L, ACTION_DOWN, 0, 0, 0));
    queue_event(make_event(KIND_KEY, 16'h0202, SCAN_ALT_R, ACTION_DOWN, 0, 0, 0));
    queue_event(make_event(KIND_KEY, 16'h0303, SCAN_ALT_R, ACTION_UP, 0, 0, 0));
    queue_event(make_event(KIND_KEY, 16'h0404, SCAN_CTRL_L, ACTION_UP, 0, 0, 0));
    queue_event(make_event(KIND_KEY, 16'h0505, SCAN_CAPS_LOCK, ACTION_REPEAT, 0, 0, 0));
    queue_event(make_event(KIND_KEY, 16'h0606, SCAN_NUM_LOCK, ACTION_UNUSED, 1, 1, 1));
    queue_event(make_event(KIND_KEY, 16'h0707, 10'd767, ACTION_DOWN, 0, 0, 0));
    queue_event(make_event(KIND_KEY, 16'h0808, 10'd0, ACTION_UP, 0, 0, 0));
    queue_event(make_event(KIND_KEY, 16'h0909, SCAN_SCREEN_LOCK, ACTION_DOWN, 0, 0, 0));
    queue_event(make_event(KIND_KEY, 16'h0A0A, SCAN_SCREEN_LOCK, ACTION_UP, 0, 0, 0));
    queue_event(make_event(KIND_KEY, 16'h0B0B, SCAN_META_R, ACTION_UP, 0, 0, 0));
    queue_event(make_event(KIND_POINTER, 16'h0C0C, 10'd767, ACTION_UP, 0, 1, 1));
    queue_event(make_event(KIND_POINTER, 16'h0D0D, 10'd0, ACTION_DOWN, 1, 0, 0));
    queue_event(make_event(KIND_KEY, 16'h0E0E, SCAN_META_L, ACTION_UP, 0, 0, 0));
    queue_event(make_event(KIND_TOUCH, 16'h0F0F, 10'd0, ACTION_DOWN, 0, 1, 1));
    queue_event(make_event(KIND_TOUCH, 16'h1010, 10'd0, ACTION_DOWN, 0, 1, 0));
    queue_event(make_event(KIND_TOUCH, 16'h1111, 10'd0, ACTION_DOWN, 1, 0, 1));
    queue_event(make_event(KIND_TOUCH, 16'h1212, 10'd0, ACTION_DOWN, 1, 15, 1));
    queue_event(make_event(KIND_OTHER, 16'hFFFF, 10'd767, ACTION_UNUSED, 1, 15, 1));
    queue_event(make_event(KIND_OTHER, 16'h0000, 10'd0, ACTION_DOWN, 0, 1, 1));
    settle_block();

    write_chord_cfg(1'b0);
    queue_saturation_run();
    settle_block();

    write_chord_cfg(1'b1);
    queue_saturation_run();
    settle_block();

    hold_req <= ~hold_req;
    start_cnt = queued_cnt;
    while (queued_cnt - start_cnt < HOLD_ITEMS) queue_chord_run();
    settle_block();

    for (int b = 0; b < BATCHES; b++) begin
      if (b % 3 == 0) begin
        settle_block();
        write_chord_cfg(1'($urandom_range(1)));
      end
      set_idling(b % 5);
      start_cnt = queued_cnt;
      while (queued_cnt - start_cnt < BATCH_ITEMS) begin
        if ($urandom_range(9) < 7) queue_chord_run();
        else queue_event(any_event());
      end
      if (b % 2 == 1) settle_block();
    end
    settle_block();
    repeat (20) @(posedge clk);

    $display("Ran %0d events under both chord settings and four idle patterns.", accepted_cnt);
    $display("Checked %0d results, including %0d replays and %0d overflows.",
             checked_cnt, replay_cnt, overflow_cnt);
    if (fail_cnt == 0 && expected_dispatches.size() == 0) begin
      $display("tb_sticky_modifier_key_filter passed");
    end else begin
      $display("%0d mismatches, %0d results never seen", fail_cnt,
               expected_dispatches.size());
      $display("tb_sticky_modifier_key_filter failed");
    end
    $finish;
  end

endmodule
